// File: src/slpq_pkg.sv
`default_nettype none

package slpq_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int PRIO_W    = 16;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = $clog2(DEPTH_DEF + 1);
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [PRIO_W-1:0]    in_prio;
      logic [PAYLOAD_W-1:0] in_payload;
   } req_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    out_prio;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [STATUS_W-1:0]  status;
      logic                 is_empty;
      logic [COUNT_W-1:0]   entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/sorted_list_priority_queue_core.sv
`default_nettype none

// Priority queue kept as a sorted singly linked list over slot memories.
// Request beats carry a command (insert, remove minimum, clear) with the
// priority and payload of an entry to insert. Every request gives exactly
// one response beat with the removed entry (zero otherwise), a status code,
// the empty flag and the entry count after the command.
// One request is handled at a time; req_stall is high while it is in work.
// An insert into an empty list or ahead of the current head is linked at
// once; otherwise the list is walked past each entry that is not greater,
// then the new slot and its predecessor are linked. Taking a slot from the
// released-slot list first reads its link. Clear, unused codes and refused
// commands go straight to the response.
// The walk reads one list entry per cycle from the slot memories (one read
// port each), which sets the insert time.
// A finished response waits in an output register while rsp_stall is high;
// the next request is already taken meanwhile, but its response waits for
// the register to empty. Reset empties the queue; no clearing pass is made.
module sorted_list_priority_queue_core
   #(
   parameter int DEPTH = slpq_pkg::DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire slpq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output slpq_pkg::rsp_type      rsp_data
);

   import slpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int DW = PRIO_W + PAYLOAD_W;
   localparam logic [LW-1:0] NIL = LW'(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_PLACE,
      S_HEAD,
      S_WALK,
      S_LINK1,
      S_LINK2,
      S_POP,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [LW-1:0]        head_ff, head_in;
   logic [LW-1:0]        free_ff, free_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic [LW-1:0]        nx_ff, nx_in;
   logic [PRIO_W-1:0]    item_prio_ff, item_prio_in;
   logic [PAYLOAD_W-1:0] item_payload_ff, item_payload_in;
   logic [PRIO_W-1:0]    res_prio_ff, res_prio_in;
   logic [PAYLOAD_W-1:0] res_payload_ff, res_payload_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic          data_we;
   logic [DW-1:0] data_wd;
   logic [DW-1:0] data_rd;
   logic          link_we;
   logic [AW-1:0] link_wa;
   logic [LW-1:0] link_wd;
   logic [LW-1:0] link_rd;
   logic [AW-1:0] rd_addr;
   logic [PRIO_W-1:0] rd_prio;

   // Both memories are read at the same slot; data is written only at slot_ff.
   slpq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (slot_ff),
      .wr_data (data_wd),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   slpq_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   assign rd_prio = data_rd[DW-1 -: PRIO_W];
   assign data_wd = {item_prio_ff, item_payload_ff};

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      free_in         = free_ff;
      cnt_in          = cnt_ff;
      slot_in         = slot_ff;
      cur_in          = cur_ff;
      nx_in           = nx_ff;
      item_prio_in    = item_prio_ff;
      item_payload_in = item_payload_ff;
      res_prio_in     = res_prio_ff;
      res_payload_in  = res_payload_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      data_we         = 1'b0;
      link_we         = 1'b0;
      link_wa         = slot_ff;
      link_wd         = nx_ff;
      rd_addr         = head_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_prio_in    = req_data.in_prio;
               item_payload_in = req_data.in_payload;
               res_prio_in     = '0;
               res_payload_in  = '0;
               res_status_in   = STATUS_OK;
               state_in        = S_DONE;
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (cnt_ff >= NIL) begin
                        res_status_in = STATUS_FULL;
                     end else if (free_ff < NIL) begin
                        slot_in  = free_ff[AW-1:0];
                        rd_addr  = free_ff[AW-1:0];
                        state_in = S_ALLOC;
                     end else begin
                        // With no released slot, the used slots are exactly
                        // those below the count.
                        slot_in  = cnt_ff[AW-1:0];
                        state_in = S_PLACE;
                     end
                  end
                  CMD_REMOVE: begin
                     if (cnt_ff == '0 || head_ff >= NIL) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        rd_addr  = head_ff[AW-1:0];
                        state_in = S_POP;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in  = '0;
                     head_in = NIL;
                     free_in = NIL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ALLOC: begin
            free_in  = link_rd;
            state_in = S_PLACE;
         end
         S_PLACE: begin
            data_we = 1'b1;
            if (head_ff >= NIL) begin
               link_we  = 1'b1;
               link_wd  = head_ff;
               head_in  = LW'(slot_ff);
               cnt_in   = cnt_ff + LW'(1);
               state_in = S_DONE;
            end else begin
               rd_addr  = head_ff[AW-1:0];
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (item_prio_ff < rd_prio) begin
               link_we  = 1'b1;
               link_wd  = head_ff;
               head_in  = LW'(slot_ff);
               cnt_in   = cnt_ff + LW'(1);
               state_in = S_DONE;
            end else begin
               cur_in = head_ff[AW-1:0];
               nx_in  = link_rd;
               if (link_rd >= NIL) begin
                  state_in = S_LINK1;
               end else begin
                  rd_addr  = link_rd[AW-1:0];
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // Entries of equal priority are passed, which keeps them in FIFO order.
            if (rd_prio > item_prio_ff) begin
               state_in = S_LINK1;
            end else begin
               cur_in = nx_ff[AW-1:0];
               nx_in  = link_rd;
               if (link_rd >= NIL) begin
                  state_in = S_LINK1;
               end else begin
                  rd_addr = link_rd[AW-1:0];
               end
            end
         end
         S_LINK1: begin
            link_we  = 1'b1;
            link_wa  = slot_ff;
            link_wd  = nx_ff;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            link_we  = 1'b1;
            link_wa  = cur_ff;
            link_wd  = LW'(slot_ff);
            cnt_in   = cnt_ff + LW'(1);
            state_in = S_DONE;
         end
         S_POP: begin
            res_prio_in    = rd_prio;
            res_payload_in = data_rd[PAYLOAD_W-1:0];
            head_in        = link_rd;
            link_we        = 1'b1;
            link_wa        = head_ff[AW-1:0];
            link_wd        = free_ff;
            free_in        = head_ff;
            cnt_in         = cnt_ff - LW'(1);
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.out_prio    = res_prio_ff;
               rsp_data_in.out_payload = res_payload_ff;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.is_empty    = (cnt_ff == '0);
               rsp_data_in.entry_count = COUNT_W'(cnt_ff);
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff         <= slot_in;
      cur_ff          <= cur_in;
      nx_ff           <= nx_in;
      item_prio_ff    <= item_prio_in;
      item_payload_ff <= item_payload_in;
      res_prio_ff     <= res_prio_in;
      res_payload_ff  <= res_payload_in;
      res_status_ff   <= res_status_in;
      rsp_data_ff     <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         free_ff      <= NIL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: src/slpq_ram.sv
`default_nettype none

module slpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import slpq_pkg::*;

   localparam int QDEPTH       = DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1350;
   localparam int STUCK_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 150;
   localparam int REPORT_MAX   = 10;

   // The block ignores this code; it has no name in the package.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type   pending_reqs[$];
   rsp_type   expected_rsps[$];
   entry_type queued_entries[$];

   int req_issued    = 0;
   int req_accepted  = 0;
   int total_reqs    = 0;
   int mismatches    = 0;
   int stuck_cycles  = 0;
   int planned_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   sorted_list_priority_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one command to the shadow queue and returns the response it must give.
   function automatic rsp_type queue_apply(req_type r);
      rsp_type   o;
      entry_type e;
      int        pos;
      o = '0;
      case (r.cmd)
         CMD_INSERT: begin
            if (queued_entries.size() >= QDEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               e.prio    = r.in_prio;
               e.payload = r.in_payload;
               // Equal priorities queue up behind each other.
               pos = 0;
               while (pos < queued_entries.size() && queued_entries[pos].prio <= r.in_prio)
                  pos++;
               queued_entries.insert(pos, e);
            end
         end
         CMD_REMOVE: begin
            if (queued_entries.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               e             = queued_entries.pop_front();
               o.out_prio    = e.prio;
               o.out_payload = e.payload;
            end
         end
         CMD_CLEAR: begin
            queued_entries.delete();
         end
         default: begin
         end
      endcase
      o.is_empty    = (queued_entries.size() == 0);
      o.entry_count = COUNT_W'(queued_entries.size());
      return o;
   endfunction

   function automatic void plan_req(logic [CMD_W-1:0] cmd, logic [PRIO_W-1:0] prio,
                                    logic [PAYLOAD_W-1:0] payload);
      req_type r;
      r.cmd        = cmd;
      r.in_prio    = prio;
      r.in_payload = payload;
      pending_reqs.push_back(r);
      case (cmd)
         CMD_INSERT: if (planned_count < QDEPTH) planned_count++;
         CMD_REMOVE: if (planned_count > 0) planned_count--;
         CMD_CLEAR:  planned_count = 0;
         default: begin
         end
      endcase
   endfunction

   // A narrow range in four of ten picks so that ties are common, with extremes and full-range values mixed in.
   function automatic logic [PRIO_W-1:0] pick_prio();
      logic [PRIO_W-1:0] p;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: p = PRIO_W'($urandom_range(0, 7));
         4:          p = '0;
         5:          p = '1;
         default:    p = PRIO_W'($urandom);
      endcase
      return p;
   endfunction

   always @(negedge clock) begin
      if (req_accepted < total_reqs / 3) begin
         send_idle_pct = 8;
         recv_idle_pct = 64;
      end else if (req_accepted < 2 * total_reqs / 3) begin
         send_idle_pct = 64;
         recv_idle_pct = 8;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      // A beat in flight stays on the bus until it is taken.
      if (!reset && (!req_valid || req_accepted == req_issued)) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected response beat: prio %h payload %h status %0d count %0d",
                           rsp_data.out_prio, rsp_data.out_payload, rsp_data.status,
                           rsp_data.entry_count);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.out_prio !== want.out_prio ||
                   rsp_data.out_payload !== want.out_payload ||
                   rsp_data.status !== want.status ||
                   rsp_data.is_empty !== want.is_empty ||
                   rsp_data.entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $write("mismatch (expected/actual): prio %h/%h payload %h/%h ",
                            want.out_prio, rsp_data.out_prio,
                            want.out_payload, rsp_data.out_payload);
                     $display("status %0d/%0d empty %b/%b count %0d/%0d",
                              want.status, rsp_data.status,
                              want.is_empty, rsp_data.is_empty,
                              want.entry_count, rsp_data.entry_count);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            expected_rsps.push_back(queue_apply(req_data));
            req_accepted++;
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int   counted;
      int   mode;
      int   burst;
      int   sel;
      logic timed_out;

      // Directed part: empty removal, ignored code, extremes, ties, clear.
      plan_req(CMD_REMOVE, '1, '1);
      plan_req(CMD_UNUSED, '1, '1);
      plan_req(CMD_INSERT, 16'hffff, 32'hffffffff);
      plan_req(CMD_INSERT, 16'h0000, 32'h00000000);
      plan_req(CMD_INSERT, 16'h8000, 32'h0000000a);
      plan_req(CMD_INSERT, 16'h8000, 32'h0000000b);
      plan_req(CMD_INSERT, 16'h8000, 32'h0000000c);
      plan_req(CMD_INSERT, 16'h0000, 32'h00000001);
      plan_req(CMD_UNUSED, '0, '0);
      repeat (6) plan_req(CMD_REMOVE, '0, '0);
      plan_req(CMD_REMOVE, '0, '0);
      plan_req(CMD_INSERT, 16'h1234, 32'h5555aaaa);
      plan_req(CMD_INSERT, 16'h0005, 32'haaaa5555);
      plan_req(CMD_CLEAR, '1, '1);
      plan_req(CMD_REMOVE, '0, '0);
      plan_req(CMD_INSERT, 16'h0007, 32'h12345678);
      plan_req(CMD_REMOVE, '0, '0);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode <= 2) begin
            // Fill to the brim, then push against the full queue.
            while (planned_count < QDEPTH) begin
               plan_req(CMD_INSERT, pick_prio(), $urandom);
               counted++;
            end
            repeat ($urandom_range(1, 3)) begin
               plan_req(CMD_INSERT, pick_prio(), $urandom);
               counted++;
            end
         end else if (mode <= 4) begin
            while (planned_count > 0) begin
               plan_req(CMD_REMOVE, PRIO_W'($urandom), $urandom);
               counted++;
            end
            repeat ($urandom_range(1, 2)) begin
               plan_req(CMD_REMOVE, PRIO_W'($urandom), $urandom);
               counted++;
            end
         end else if (mode <= 7) begin
            burst = $urandom_range(10, 40);
            repeat (burst) begin
               sel = $urandom_range(0, 99);
               if (sel < 60) begin
                  plan_req(CMD_INSERT, pick_prio(), $urandom);
                  counted++;
               end else if (sel < 95) begin
                  plan_req(CMD_REMOVE, PRIO_W'($urandom), $urandom);
                  counted++;
               end else if (sel < 98) begin
                  plan_req(CMD_CLEAR, PRIO_W'($urandom), $urandom);
                  counted++;
               end else begin
                  plan_req(CMD_UNUSED, PRIO_W'($urandom), $urandom);
               end
            end
         end else if (mode == 8) begin
            plan_req(CMD_CLEAR, PRIO_W'($urandom), $urandom);
            plan_req(CMD_UNUSED, PRIO_W'($urandom), $urandom);
            plan_req(CMD_REMOVE, PRIO_W'($urandom), $urandom);
            counted += 2;
         end else begin
            // Many equal keys: arrival order must survive.
            burst = $urandom_range(8, 20);
            repeat (burst) begin
               plan_req(CMD_INSERT, PRIO_W'($urandom_range(0, 1)), $urandom);
               counted++;
            end
            repeat (burst) begin
               plan_req(CMD_REMOVE, PRIO_W'($urandom), $urandom);
               counted++;
            end
         end
      end
      total_reqs = pending_reqs.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while ((req_accepted < total_reqs || expected_rsps.size() != 0) &&
             stuck_cycles < STUCK_LIMIT)
         @(negedge clock);
      timed_out = (stuck_cycles >= STUCK_LIMIT);
      if (!timed_out)
         repeat (TAIL_CYCLES) @(negedge clock);

      if (!timed_out && mismatches == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
